@@ rtl/pwm_prescaler_reload_factorizer_assert.svh @@
// ----------------------------------------------------------------------------
// PWM prescaler factorizer assertion macros
// Shorthand for clocked implications checked on the block's ports.
// ----------------------------------------------------------------------------
`ifndef PWM_PRESCALER_RELOAD_FACTORIZER_ASSERT_SVH
`define PWM_PRESCALER_RELOAD_FACTORIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PPRF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PPRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pprf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler factorizer package
// Widths, microcode encodings, control word types and the microcode ROM.
// ----------------------------------------------------------------------------
package pprf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PSC_W     = 17;
    localparam int unsigned PC_W      = 4;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned OP_W      = 4;
    localparam int unsigned COND_W    = 3;

    localparam logic [DATA_W-1:0] CLK_HZ_RESET = 32'd24000000;
    localparam logic [DATA_W-1:0] SQRT_BIT0    = 32'h4000_0000;
    localparam logic [CNT_W-1:0]  DIV_LAST     = 5'd31;
    localparam logic [CNT_W-1:0]  SQRT_LAST    = 5'd15;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_LD_CLK    = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd2;
    localparam logic [OP_W-1:0] OP_SAT_PER   = 4'd3;
    localparam logic [OP_W-1:0] OP_LD_SQRT   = 4'd4;
    localparam logic [OP_W-1:0] OP_SQRT_STEP = 4'd5;
    localparam logic [OP_W-1:0] OP_ROUND     = 4'd6;
    localparam logic [OP_W-1:0] OP_LD_TRIAL  = 4'd7;
    localparam logic [OP_W-1:0] OP_DEC_TRIAL = 4'd8;
    localparam logic [OP_W-1:0] OP_OUT_FACT  = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT_ERR   = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT_ZERO  = 4'd11;

    // jump conditions
    localparam logic [COND_W-1:0] C_NONE      = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_NO_START  = 3'd2;
    localparam logic [COND_W-1:0] C_FREQ_ZERO = 3'd3;
    localparam logic [COND_W-1:0] C_PER_ZERO  = 3'd4;
    localparam logic [COND_W-1:0] C_CNT_NZ    = 3'd5;
    localparam logic [COND_W-1:0] C_REM_ZERO  = 3'd6;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] PC_CHK_FREQ   = 4'd1;
    localparam logic [PC_W-1:0] PC_LD_CLK     = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV_LOOP   = 4'd3;
    localparam logic [PC_W-1:0] PC_SAT        = 4'd4;
    localparam logic [PC_W-1:0] PC_LD_SQRT    = 4'd5;
    localparam logic [PC_W-1:0] PC_SQRT_LOOP  = 4'd6;
    localparam logic [PC_W-1:0] PC_ROUND      = 4'd7;
    localparam logic [PC_W-1:0] PC_TRIAL      = 4'd8;
    localparam logic [PC_W-1:0] PC_TRIAL_LOOP = 4'd9;
    localparam logic [PC_W-1:0] PC_TEST_REM   = 4'd10;
    localparam logic [PC_W-1:0] PC_DEC        = 4'd11;
    localparam logic [PC_W-1:0] PC_FACT       = 4'd12;
    localparam logic [PC_W-1:0] PC_ERR        = 4'd13;
    localparam logic [PC_W-1:0] PC_ZERO       = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        logic start;
        logic freq_zero;
        logic per_zero;
        logic cnt_nz;
        logic rem_zero;
    } t_status;

    // Branch taken goes to target, otherwise fall through to the next step.
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_IDLE:       w = '{op: OP_NOP,       cond: C_NO_START,  target: PC_IDLE};
            PC_CHK_FREQ:   w = '{op: OP_NOP,       cond: C_FREQ_ZERO, target: PC_ERR};
            PC_LD_CLK:     w = '{op: OP_LD_CLK,    cond: C_NONE,      target: PC_IDLE};
            PC_DIV_LOOP:   w = '{op: OP_DIV_STEP,  cond: C_CNT_NZ,    target: PC_DIV_LOOP};
            PC_SAT:        w = '{op: OP_SAT_PER,   cond: C_NONE,      target: PC_IDLE};
            PC_LD_SQRT:    w = '{op: OP_LD_SQRT,   cond: C_PER_ZERO,  target: PC_ZERO};
            PC_SQRT_LOOP:  w = '{op: OP_SQRT_STEP, cond: C_CNT_NZ,    target: PC_SQRT_LOOP};
            PC_ROUND:      w = '{op: OP_ROUND,     cond: C_NONE,      target: PC_IDLE};
            PC_TRIAL:      w = '{op: OP_LD_TRIAL,  cond: C_NONE,      target: PC_IDLE};
            PC_TRIAL_LOOP: w = '{op: OP_DIV_STEP,  cond: C_CNT_NZ,    target: PC_TRIAL_LOOP};
            PC_TEST_REM:   w = '{op: OP_NOP,       cond: C_REM_ZERO,  target: PC_FACT};
            PC_DEC:        w = '{op: OP_DEC_TRIAL, cond: C_ALWAYS,    target: PC_TRIAL};
            PC_FACT:       w = '{op: OP_OUT_FACT,  cond: C_ALWAYS,    target: PC_IDLE};
            PC_ERR:        w = '{op: OP_OUT_ERR,   cond: C_ALWAYS,    target: PC_IDLE};
            PC_ZERO:       w = '{op: OP_OUT_ZERO,  cond: C_ALWAYS,    target: PC_IDLE};
            default:       w = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/pwm_prescaler_reload_factorizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler / reload factorizer
// Splits the timer period for a wanted PWM frequency into prescaler and reload.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  config   | i_cfg_we, i_cfg_wdata (core clock Hz)   | write on any edge with we high
//  request  | i_start, o_busy, i_target_freq_hz       | beat taken at start && !busy
//  result   | o_done, o_prescale_value, o_reload_value| one-cycle strobe, no stall
//           | o_zero_freq_error                       |
//
//  Per beat the sequencer checks the frequency, runs the shared bit-serial
//  divider for the period, saturates it, takes its root and rounds it, then
//  walks T = (rounded root - prescaler + 1) trial divisors; each trial is one
//  divider pass plus setup, remainder test and step down. Worst case is a prime
//  period. Zero frequency strobes after the check, zero period after root load.
//  Reset (synchronous, active low) returns the sequencer to idle and the core
//  clock register to 24 MHz. The result strobe cannot be stalled; busy drops on
//  the strobe cycle, so the next request may be taken right then.
//
module pwm_prescaler_reload_factorizer #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pprf_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic                        i_start,
    input  logic [pprf_pkg::DATA_W-1:0] i_target_freq_hz,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [pprf_pkg::PSC_W-1:0]  o_prescale_value,
    output logic [pprf_pkg::DATA_W-1:0] o_reload_value,
    output logic                        o_zero_freq_error
);
    import pprf_pkg::*;

    t_uword  w_uword;
    t_status w_status;
    logic    w_busy;
    logic    w_accept;

    // take a request beat only while the sequencer sits at its idle step
    assign w_accept = i_start && !w_busy;

    // program sequencer: step counter plus microcode ROM, branching on status
    pprf_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uword  (w_uword),
        .o_busy   (w_busy)
    );

    // datapath: divider for period and trial remainders, root for search start
    pprf_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_accept          (w_accept),
        .i_start           (i_start),
        .i_target_freq_hz  (i_target_freq_hz),
        .i_uword           (w_uword),
        .o_status          (w_status),
        .o_prescale_value  (o_prescale_value),
        .o_reload_value    (o_reload_value),
        .o_zero_freq_error (o_zero_freq_error),
        .o_done            (o_done)
    );

    assign o_busy = w_busy;

endmodule

@@ rtl/pprf_useq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler factorizer sequencer
// Step counter, microcode ROM lookup and conditional branch logic.
// ----------------------------------------------------------------------------
module pprf_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pprf_pkg::t_status i_status,
    output pprf_pkg::t_uword  o_uword,
    output logic              o_busy
);
    import pprf_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uw;
    logic            w_take;

    assign w_uw = uc_rom(r_pc);

    always_comb begin
        case (w_uw.cond)
            C_NONE:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_START:  w_take = !i_status.start;
            C_FREQ_ZERO: w_take = i_status.freq_zero;
            C_PER_ZERO:  w_take = i_status.per_zero;
            C_CNT_NZ:    w_take = i_status.cnt_nz;
            C_REM_ZERO:  w_take = i_status.rem_zero;
            default:     w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_uw;
    assign o_busy  = (r_pc != PC_IDLE);

endmodule

@@ rtl/pprf_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler factorizer datapath
// Shared restoring divider, bit-pair square root and result registers.
// ----------------------------------------------------------------------------
module pprf_dpath #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pprf_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic                          i_accept,
    input  logic                          i_start,
    input  logic [pprf_pkg::DATA_W-1:0]   i_target_freq_hz,
    input  pprf_pkg::t_uword              i_uword,
    output pprf_pkg::t_status             o_status,
    output logic [pprf_pkg::PSC_W-1:0]    o_prescale_value,
    output logic [pprf_pkg::DATA_W-1:0]   o_reload_value,
    output logic                          o_zero_freq_error,
    output logic                          o_done
);
    import pprf_pkg::*;

    localparam logic [DATA_W-1:0] CNT_MAX = DATA_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [DATA_W-1:0]      r_clk_hz;
    logic [DATA_W-1:0]      r_freq;
    logic [DATA_W-1:0]      r_num;
    logic [DATA_W-1:0]      r_rem;
    logic [DATA_W-1:0]      r_den;
    logic [CNT_W-1:0]       r_cnt;
    logic [COUNT_WIDTH-1:0] r_per;
    logic [DATA_W-1:0]      r_sv;
    logic [DATA_W-1:0]      r_res;
    logic [DATA_W-1:0]      r_bit;
    logic [PSC_W-1:0]       r_trial;
    logic [PSC_W-1:0]       r_psc;
    logic [DATA_W-1:0]      r_rld;
    logic                   r_err;
    logic                   r_done;

    logic [DATA_W:0]        w_part;
    logic [DATA_W:0]        w_diff;
    logic                   w_ge;
    logic [DATA_W-1:0]      n_rem;
    logic [DATA_W-1:0]      n_num;
    logic [DATA_W-1:0]      w_sum;
    logic                   w_sq_ge;
    logic [COUNT_WIDTH-1:0] n_per;
    logic [PSC_W-1:0]       n_trial;

    // one restoring divide step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_part = {r_rem, r_num[DATA_W-1]};
        w_diff = w_part - {1'b0, r_den};
        w_ge   = !w_diff[DATA_W];
        n_rem  = w_ge ? w_diff[DATA_W-1:0] : w_part[DATA_W-1:0];
        n_num  = {r_num[DATA_W-2:0], w_ge};
    end

    always_comb begin
        w_sum   = r_res + r_bit;
        w_sq_ge = (r_sv >= w_sum);
        n_per   = (r_num > CNT_MAX) ? {COUNT_WIDTH{1'b1}} : r_num[COUNT_WIDTH-1:0];
        // leftover sv is period minus root squared: round up when it exceeds the root
        n_trial = (r_sv > r_res) ? r_res[PSC_W-1:0] + 1'b1 : r_res[PSC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_HZ_RESET;
            r_done   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
            r_done <= (i_uword.op == OP_OUT_FACT) || (i_uword.op == OP_OUT_ERR) ||
                      (i_uword.op == OP_OUT_ZERO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_freq <= i_target_freq_hz;
        end
        case (i_uword.op)
            OP_LD_CLK: begin
                r_num <= r_clk_hz;
                r_rem <= '0;
                r_den <= r_freq;
                r_cnt <= DIV_LAST;
            end
            OP_DIV_STEP: begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_SAT_PER: begin
                r_per <= n_per;
            end
            OP_LD_SQRT: begin
                r_sv  <= DATA_W'(r_per);
                r_res <= '0;
                r_bit <= SQRT_BIT0;
                r_cnt <= SQRT_LAST;
            end
            OP_SQRT_STEP: begin
                if (w_sq_ge) begin
                    r_sv  <= r_sv - w_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_ROUND: begin
                r_trial <= n_trial;
            end
            OP_LD_TRIAL: begin
                r_num <= DATA_W'(r_per);
                r_rem <= '0;
                r_den <= DATA_W'(r_trial);
                r_cnt <= DIV_LAST;
            end
            OP_DEC_TRIAL: begin
                r_trial <= r_trial - 1'b1;
            end
            OP_OUT_FACT: begin
                r_psc <= r_trial;
                r_rld <= r_num;
                r_err <= 1'b0;
            end
            OP_OUT_ERR: begin
                r_psc <= '0;
                r_rld <= '0;
                r_err <= 1'b1;
            end
            OP_OUT_ZERO: begin
                r_psc <= '0;
                r_rld <= '0;
                r_err <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_status.start     = i_start;
    assign o_status.freq_zero = (r_freq == '0);
    assign o_status.per_zero  = (r_per == '0);
    assign o_status.cnt_nz    = (r_cnt != '0);
    assign o_status.rem_zero  = (r_rem == '0);

    assign o_prescale_value  = r_psc;
    assign o_reload_value    = r_rld;
    assign o_zero_freq_error = r_err;
    assign o_done            = r_done;

endmodule

@@ rtl/pprf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler factorizer port checker
// Port-level checks on request acceptance and result consistency.
// ----------------------------------------------------------------------------
`include "pwm_prescaler_reload_factorizer_assert.svh"

module pprf_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [16:0] o_prescale_value,
    input logic [31:0] o_reload_value,
    input logic        o_zero_freq_error
);

    `PPRF_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "busy not raised after beat")

    `PPRF_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe held two cycles")

    `PPRF_ASSERT_IMPLY(a_err_zero, o_done && o_zero_freq_error,
        (o_prescale_value == 17'd0) && (o_reload_value == 32'd0),
        "zero frequency result not zero")

    `PPRF_ASSERT_IMPLY(a_zero_pair, o_done && !o_zero_freq_error,
        (o_prescale_value == 17'd0) == (o_reload_value == 32'd0),
        "prescaler and reload disagree on zero")

endmodule

bind pwm_prescaler_reload_factorizer pprf_port_checker u_pprf_checker (.*);

@@ test/pprf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prescaler / reload result checker
// Tracks the core clock register, works out the prescaler and reload for each
// request beat taken and compares them in order with the strobed results.
// ----------------------------------------------------------------------------
module pprf_checker #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pprf_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [pprf_pkg::DATA_W-1:0] i_target_freq_hz,
    input  logic                        i_done,
    input  logic [pprf_pkg::PSC_W-1:0]  i_prescale_value,
    input  logic [pprf_pkg::DATA_W-1:0] i_reload_value,
    input  logic                        i_zero_freq_error,
    output int                          o_mismatch_count,
    output int                          o_pending_count,
    output int                          o_result_count,
    output int                          o_error_count
);
    import pprf_pkg::*;

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    typedef struct packed {
        logic [PSC_W-1:0]  prescale;
        logic [DATA_W-1:0] reload;
        logic              zero_freq;
    } t_factor_pair;

    logic [DATA_W-1:0] core_clock_hz;
    t_factor_pair      expected_factors[$];

    function automatic t_factor_pair factor_period(input logic [DATA_W-1:0] clk_hz,
                                                   input logic [DATA_W-1:0] freq_hz);
        t_factor_pair      fp;
        logic [63:0]       wide_period;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] root;
        logic [DATA_W-1:0] probe;
        logic [DATA_W-1:0] trial;
        fp = '0;
        if (freq_hz == '0) begin
            fp.zero_freq = 1'b1;
            return fp;
        end
        wide_period = 64'(clk_hz / freq_hz);
        if (wide_period > COUNT_MAX) begin
            wide_period = COUNT_MAX;
        end
        period = wide_period[DATA_W-1:0];
        // floor root, settle one bit at a time from the top
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            probe = root | (32'd1 << b);
            if (64'(probe) * 64'(probe) <= 64'(period)) begin
                root = probe;
            end
        end
        // round half up: bump when the remainder passes the root
        trial = (period - root * root > root) ? root + 32'd1 : root;
        // walk down to the first divisor; a zero period leaves both at zero
        while (trial != '0) begin
            if (period % trial == '0) begin
                fp.prescale = trial[PSC_W-1:0];
                fp.reload   = period / trial;
                break;
            end
            trial--;
        end
        return fp;
    endfunction

    task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (want !== got) begin
            o_mismatch_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // Sample mid-cycle: every port is stable, so a beat seen here lands on the
    // next rising edge.
    always @(negedge i_clk) begin : sample
        t_factor_pair want;
        if (!i_rst_n) begin
            core_clock_hz = CLK_HZ_RESET;
            expected_factors.delete();
        end else begin
            // retire the result first: busy drops on the strobe cycle, so a
            // new request may be taken in the very same cycle
            if (i_done) begin
                o_result_count++;
                if (i_zero_freq_error) begin
                    o_error_count++;
                end
                if (expected_factors.size() == 0) begin
                    o_mismatch_count++;
                    $display("%0t: result with nothing expected, expected none actual %0d/%0d/%0d",
                             $time, i_prescale_value, i_reload_value, i_zero_freq_error);
                end else begin
                    want = expected_factors.pop_front();
                    report_field("prescale_value", 32'(want.prescale), 32'(i_prescale_value));
                    report_field("reload_value", want.reload, i_reload_value);
                    report_field("zero_freq_error", 32'(want.zero_freq),
                                 32'(i_zero_freq_error));
                end
            end
            if (i_cfg_we) begin
                core_clock_hz = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                expected_factors.push_back(factor_period(core_clock_hz, i_target_freq_hz));
            end
        end
        o_pending_count = expected_factors.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler / reload factorizer testbench
// Drives frequency requests under a range of core clock settings, from fixed
// corner cases to random phases, with random sender gaps; the checker beside
// the block predicts each prescaler / reload pair and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
    import pprf_pkg::*;

    // Every random period is either below about 8k or a product of two near
    // factors, so the divisor search never walks more than about a hundred trials.
    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int unsigned TAIL_CYCLES  = 100;
    localparam int unsigned RANDOM_BEATS = 80;
    localparam int unsigned QUIET_AFTER  = 64;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [DATA_W-1:0] i_cfg_wdata;
    logic              i_start;
    logic [DATA_W-1:0] i_target_freq_hz;
    logic              o_busy;
    logic              o_done;
    logic [PSC_W-1:0]  o_prescale_value;
    logic [DATA_W-1:0] o_reload_value;
    logic              o_zero_freq_error;

    int          mismatch_count;
    int          pending_count;
    int          result_count;
    int          error_count;
    int          beats_sent;
    int          random_beats;
    int          clock_settings;
    int unsigned cycle_count;
    bit          allow_gaps;

    pwm_prescaler_reload_factorizer #(
        .COUNT_WIDTH(32)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (i_start),
        .i_target_freq_hz (i_target_freq_hz),
        .o_busy           (o_busy),
        .o_done           (o_done),
        .o_prescale_value (o_prescale_value),
        .o_reload_value   (o_reload_value),
        .o_zero_freq_error(o_zero_freq_error)
    );

    pprf_checker #(
        .COUNT_WIDTH(32)
    ) u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_target_freq_hz (i_target_freq_hz),
        .i_done           (o_done),
        .i_prescale_value (o_prescale_value),
        .i_reload_value   (o_reload_value),
        .i_zero_freq_error(o_zero_freq_error),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_result_count   (result_count),
        .o_error_count    (error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one request beat and hold it until taken. Call right after a
    // rising edge; return on the edge that takes the beat.
    task automatic send_beat(input logic [DATA_W-1:0] freq_hz);
        bit taken;
        // drop start for a short random burst now and then
        if (allow_gaps && $urandom_range(0, 2) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_target_freq_hz <= freq_hz;
        taken = 1'b0;
        while (!taken) begin
            // busy only moves on rising edges, so mid-cycle tells the outcome
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end
        beats_sent++;
    endtask

    // Lower start and hold off until every expected result has come back.
    task automatic drain();
        i_start <= 1'b0;
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the core clock register; only called with the block drained.
    task automatic write_core_clock(input logic [DATA_W-1:0] hz);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= hz;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        clock_settings++;
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] clk_hz;
        logic [DATA_W-1:0] freq_hz;
        logic [63:0]       wide_hz;
        int unsigned       mult;
        int unsigned       fac_hi;
        int unsigned       fac_lo;
        int unsigned       pick;
        int unsigned       tp;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        i_start          <= 1'b0;
        i_target_freq_hz <= '0;
        allow_gaps       = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset clock of 24 MHz: zero frequency, slowest request, period of
        // one, frequency just above the clock, tiny periods, high bits set.
        send_beat(32'd0);
        send_beat(32'd1);
        send_beat(32'd24000000);
        send_beat(32'd24000001);
        send_beat(32'd12000000);
        send_beat(32'd8000000);
        send_beat(32'd1000);
        send_beat(32'hFFFF_FFFF);
        send_beat(32'h8000_0000);
        drain();

        // Full-scale clock: widest period, a prime period and alternating bits.
        write_core_clock(32'hFFFF_FFFF);
        send_beat(32'd1);
        send_beat(32'd65537);
        send_beat(32'd65535);
        send_beat(32'hFFFF_FFFF);
        send_beat(32'h5555_5555);
        send_beat(32'hAAAA_AAAA);
        drain();

        // Zero clock: every period is zero, the zero-frequency flag still wins.
        write_core_clock(32'd0);
        send_beat(32'd1);
        send_beat(32'd0);
        send_beat(32'hFFFF_FFFF);
        drain();

        // Clock of one hertz.
        write_core_clock(32'd1);
        send_beat(32'd1);
        send_beat(32'd2);
        send_beat(32'd0);

        // Random phases: each drains, sets a fresh clock and sends a burst.
        while (random_beats < RANDOM_BEATS) begin
            drain();
            mult = 0;
            case ($urandom_range(0, 3))
                0: clk_hz = $urandom();
                1: clk_hz = $urandom_range(1, 5000);
                2: begin
                    // clock = mult * a * b with a, b close: a request at mult
                    // gives a wide period whose root sits right by a divisor
                    mult    = $urandom_range(1, 8);
                    fac_hi  = (mult == 1) ? $urandom_range(256, 65535)
                                          : $urandom_range(256, 23170);
                    fac_lo  = fac_hi - $urandom_range(0, 40);
                    wide_hz = 64'(mult) * 64'(fac_hi) * 64'(fac_lo);
                    clk_hz  = wide_hz[DATA_W-1:0];
                end
                default: clk_hz = 32'hFFFF_FFFF - $urandom_range(0, 3);
            endcase
            write_core_clock(clk_hz);
            repeat ($urandom_range(8, 20)) begin
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    // noise: zero, top bit set, or above the clock
                    case ($urandom_range(0, 2))
                        0: freq_hz = '0;
                        1: freq_hz = $urandom() | 32'h8000_0000;
                        default: freq_hz = (clk_hz == 32'hFFFF_FFFF) ? clk_hz :
                            clk_hz + 32'd1 + $urandom_range(0, 32'hFFFF_FFFE - clk_hz);
                    endcase
                end else if (pick < 7 && mult != 0) begin
                    freq_hz = mult;
                end else begin
                    // aim at a short period so the divisor search stays short
                    tp      = $urandom_range(1, 4096);
                    freq_hz = clk_hz / tp;
                    if (freq_hz == '0) begin
                        freq_hz = 32'd1;
                    end
                end
                send_beat(freq_hz);
                random_beats++;
                allow_gaps = (random_beats < QUIET_AFTER);
                // now and then stall the sender until all results are back
                if (allow_gaps && $urandom_range(0, 24) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests (%0d random) over %0d core clock writes,",
                 beats_sent, random_beats, clock_settings);
        $display("  zero, 1 Hz and full-scale clocks included; %0d results, %0d zero-freq flags.",
                 result_count, error_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Cycle watchdog: end a hung run.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit %0d reached with %0d results outstanding",
                 $time, LIMIT_CYCLES, pending_count);
        $display("Regression FAIL");
        $finish;
    end

endmodule
